/* rtl/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Types and constants shared by the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int AW = 35;          // component width in units of 2^-30
  localparam int TAB_LEN = 24;
  localparam int SQ_STEPS = 31;    // result bits of the square root

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } q2e_in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } q2e_out_t;

  // one CORDIC vector in flight
  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic [31:0]          acc;
    logic                 zero;
  } q2e_vec_t;

  // square root working state
  typedef struct packed {
    logic [61:0] rem;
    logic [61:0] res;
    logic signed [AW-1:0] s;
    logic                 clamp;
  } q2e_sq_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t [TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  function automatic q2e_vec_t vec_start(input logic signed [AW-1:0] y,
                                         input logic signed [AW-1:0] x);
    q2e_vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.acc = 32'h80000000;
    end else begin
      v.x = x;
      v.y = y;
      v.acc = '0;
    end
    return v;
  endfunction

  function automatic logic [15:0] angle_out(input q2e_vec_t v);
    logic [31:0] a;
    a = v.acc + 32'h8000;
    return v.zero ? 16'h0 : a[31:16];
  endfunction

endpackage

/* rtl/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation on three vectors, registered.
// ----------------------------------------------------------------------------
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic     clk,
  input  logic     en,
  input  q2e_vec_t vin [3],
  input  logic [2:0][15:0] side_in,
  output q2e_vec_t vout [3],
  output logic [2:0][15:0] side_out
);
  q2e_vec_t v_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v_nxt[k] = vin[k];
      if (vin[k].y >= 0) begin
        v_nxt[k].x = vin[k].x + (vin[k].y >>> STAGE);
        v_nxt[k].y = vin[k].y - (vin[k].x >>> STAGE);
        v_nxt[k].acc = vin[k].acc + atan_entry(STAGE);
      end else begin
        v_nxt[k].x = vin[k].x - (vin[k].y >>> STAGE);
        v_nxt[k].y = vin[k].y + (vin[k].x >>> STAGE);
        v_nxt[k].acc = vin[k].acc - atan_entry(STAGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout <= v_nxt;
      side_out <= side_in;
    end
  end
endmodule

/* rtl/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One restoring square root bit of the pitch cosine, registered.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    en,
  input  q2e_sq_t sin_i,
  input  logic [1:0][15:0] side_in,
  output q2e_sq_t sout,
  output logic [1:0][15:0] side_out
);
  localparam logic [61:0] BIT = 62'd1 << (2 * (SQ_STEPS - 1 - STEP));
  q2e_sq_t s_nxt;

  always_comb begin
    s_nxt = sin_i;
    if (sin_i.rem >= sin_i.res + BIT) begin
      s_nxt.rem = sin_i.rem - (sin_i.res + BIT);
      s_nxt.res = (sin_i.res >> 1) + BIT;
    end else begin
      s_nxt.res = sin_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sout <= s_nxt;
      side_out <= side_in;
    end
  end
endmodule

/* rtl/quaternion_to_euler.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Quaternion (Q1.15) to roll, pitch, yaw binary angles, Z-Y-X order.
// ----------------------------------------------------------------------------
// One item enters per cycle and results leave one per cycle while the pipe is
// not held, through a product stage, a sum stage, a chain of 31 square root
// cells (one result bit each) and a chain of CORDIC_STAGES vectoring cells
// (capped at 24), each one stage wide, then the output register. The whole
// pipe advances when the output register is free or being taken; out_stall
// holds it.
module quaternion_to_euler
  import q2e_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  q2e_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output q2e_out_t out_data
);
  localparam int NC = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int DEPTH = 2 + SQ_STEPS + NC + 1;

  logic en;
  logic [DEPTH-1:0] vld_r;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end

  // products, Q2.30
  logic signed [31:0] p_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= in_data.quat_w * in_data.quat_x;
      p_r[1] <= in_data.quat_y * in_data.quat_z;
      p_r[2] <= in_data.quat_x * in_data.quat_x;
      p_r[3] <= in_data.quat_y * in_data.quat_y;
      p_r[4] <= in_data.quat_w * in_data.quat_z;
      p_r[5] <= in_data.quat_x * in_data.quat_y;
      p_r[6] <= in_data.quat_z * in_data.quat_z;
      p_r[7] <= in_data.quat_w * in_data.quat_y;
      p_r[8] <= in_data.quat_z * in_data.quat_x;
    end
  end

  logic signed [AW-1:0] sr, cr, sy, cy, sp;
  localparam logic signed [AW-1:0] ONE = AW'(64'sd1 << 30);
  always_comb begin
    sr = AW'(p_r[0]) + AW'(p_r[1]); sr = sr <<< 1;
    cr = ONE - ((AW'(p_r[2]) + AW'(p_r[3])) <<< 1);
    sy = (AW'(p_r[4]) + AW'(p_r[5])) <<< 1;
    cy = ONE - ((AW'(p_r[3]) + AW'(p_r[6])) <<< 1);
    sp = (AW'(p_r[7]) - AW'(p_r[8])) <<< 1;
  end

  // sum stage: launch roll/yaw vectors and the pitch radicand
  q2e_sq_t sq [SQ_STEPS+1];
  logic [1:0][15:0] sd [SQ_STEPS+1];
  logic signed [31:0] sp_lo;
  logic signed [63:0] sp2;
  // the radicand only matters below the clamp, where sp fits 32 bits
  assign sp_lo = sp[31:0];
  assign sp2 = 64'(sp_lo) * 64'(sp_lo);
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].s <= sp;
      sq[0].clamp <= (sp >= ONE) || (sp <= -ONE);
      sq[0].rem <= 62'((64'd1 << 60) - 64'(sp2));
      sq[0].res <= '0;
      sd[0][0] <= angle_out(vec_start(sr, cr));
      sd[0][1] <= angle_out(vec_start(sy, cy));
    end
  end

  // roll and yaw vectors ride beside the root chain
  q2e_vec_t rv [SQ_STEPS+1][2];
  always_ff @(posedge clk) begin
    if (en) begin
      rv[0][0] <= vec_start(sr, cr);
      rv[0][1] <= vec_start(sy, cy);
      for (int i = 0; i < SQ_STEPS; i++) rv[i+1] <= rv[i];
    end
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    q2e_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(en), .sin_i(sq[g]), .side_in(sd[g]),
      .sout(sq[g+1]), .side_out(sd[g+1])
    );
  end

  q2e_vec_t cv [NC+1][3];
  logic [2:0][15:0] cs [NC+1];
  always_comb begin
    cv[0][0] = rv[SQ_STEPS][0];
    cv[0][1] = vec_start(sq[SQ_STEPS].s, AW'(sq[SQ_STEPS].res));
    cv[0][2] = rv[SQ_STEPS][1];
    cs[0][0] = {15'd0, sq[SQ_STEPS].clamp};
    cs[0][1] = sq[SQ_STEPS].s[AW-1] ? 16'hC000 : 16'h4000;
    cs[0][2] = sd[SQ_STEPS][0];
  end

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    q2e_cordic_cell #(.STAGE(g)) u_cell (
      .clk(clk), .en(en), .vin(cv[g]), .side_in(cs[g]),
      .vout(cv[g+1]), .side_out(cs[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.roll_angle <= angle_out(cv[NC][0]);
      out_data.yaw_angle <= angle_out(cv[NC][2]);
      out_data.pitch_clamped <= cs[NC][0][0];
      out_data.pitch_angle <= cs[NC][0][0] ? cs[NC][1] : angle_out(cv[NC][1]);
    end
  end
endmodule

/* rtl/q2e_checker.sv */
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks of the quaternion to Euler converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module q2e_checker
  import q2e_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input q2e_out_t out_data
);
  `ASSERT_CLK(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")
  `ASSERT_CLK(a_stall_link, clk, rst_n, in_stall == (out_valid && out_stall), "input stall not tied to output")
  `ASSERT_CLK(a_pitch_rng, clk, rst_n, out_valid |-> out_data.pitch_angle <= 16384 && out_data.pitch_angle >= -16384, "pitch out of range")
  `ASSERT_CLK(a_clamp, clk, rst_n, out_valid && out_data.pitch_clamped |-> out_data.pitch_angle == 16384 || out_data.pitch_angle == -16384, "clamp without quarter turn")
  `ASSERT_CLK_NR(a_reset, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
